// File: hw/rtl/tcw_pkg.sv
// Package for the text console writer: screen geometry, field widths,
// character and action codes, and helpers for cell addressing.
// Depends on nothing; text_console_writer, tcw_checker and testbench import it.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int ACT_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 2 * CHAR_W;

	localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

	localparam logic [ACT_W-1:0] ACT_STREAM = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

	// Screen rows live in the buffer as a ring; base is the physical row shown on top.
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
		input logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		sum = {1'b0, lrow} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
		input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

// File: hw/rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/text_console_writer.sv
// Text console writer top level: command sequencer around the cell buffer RAM.
// Depends on tcw_pkg and tcw_ram.
//
// Usage. Commands arrive on the s_axis stream, one per transfer: tuser holds
// the action (stream character, positioned write, clear, cell read) and tdata
// the character, row and column. Each command yields exactly one transfer on
// m_axis with the cursor position and, for a read, the cell contents. The
// attribute byte is set through the APB register at address 0.
// Timing. A stream character, positioned write or ignored byte passes through
// the EXEC and DONE states before the result is offered; a cell read also
// passes through READ, as the buffer RAM returns registered read data. A newline or
// line wrap on the bottom row blanks one buffer row in a SWEEP pass over its
// COLUMNS cells (80); a clear rewrites the whole buffer, all ROWS*COLUMNS cells (2000).
// Scrolling moves a row pointer rather than the data, so only the new bottom
// row is written. One command is processed at a time; the next may be
// accepted in the cycle its predecessor's result enters the output register.
// Reset. After arst_n is released the block writes blanks with attribute 7
// into all 2000 cells, one per cycle, and accepts no command until that pass
// ends; APB writes are taken throughout.
// Back-pressure. A result waits in the output register while m_axis_tready is
// low; a finished command then holds in place and s_axis_tready stays low.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // char_code[7:0], row[12:8], column[19:13], zeros
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // cursor_row[4:0], cursor_column[11:5],
	                                   // cell_char[19:12], cell_attr[27:20], zeros
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	logic [2:0]        state_q;
	logic [CHAR_W-1:0] text_attr_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  base_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_last_q;
	logic [CHAR_W-1:0] sweep_attr_q;
	logic [ACT_W-1:0]  act_q;
	logic [CHAR_W-1:0] chr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CHAR_W-1:0] res_char_q;
	logic [CHAR_W-1:0] res_attr_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	logic              accept;
	logic              emit;
	logic              in_range;
	logic              printable;
	logic              wraps;
	logic [ROW_W-1:0]  tgt_row;
	logic [COL_W-1:0]  tgt_col;
	logic [ADDR_W-1:0] tgt_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic              rd_en;
	logic [CELL_W-1:0] rd_data;

	// APB register file: only the attribute byte at word 0.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(text_attr_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			text_attr_q <= pwdata[CHAR_W-1:0];
		end
	end

	assign emit          = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == S_IDLE) || emit;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_range  = ({1'b0, row_q} < (ROW_W+1)'(ROWS)) &&
		({1'b0, col_q} < (COL_W+1)'(COLUMNS));
	assign printable = (chr_q != CHAR_NUL) && (chr_q != CHAR_CR) && (chr_q != CHAR_LF);
	assign wraps     = (chr_q == CHAR_LF) || (printable && cur_col_q == LAST_COL);
	assign tgt_row   = (act_q == ACT_STREAM) ? cur_row_q : row_q;
	assign tgt_col   = (act_q == ACT_STREAM) ? cur_col_q : col_q;
	assign tgt_addr  = cell_addr(phys_row(tgt_row, base_q), tgt_col);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tgt_addr;
		wr_data = {text_attr_q, chr_q};
		if (state_q == S_INIT || state_q == S_SWEEP) begin
			wr_en   = 1'b1;
			wr_addr = sweep_addr_q;
			wr_data = {sweep_attr_q, BLANK_CHAR};
		end else if (state_q == S_EXEC) begin
			wr_en = ((act_q == ACT_STREAM) && printable) || ((act_q == ACT_WRITE) && in_range);
		end
	end

	assign rd_en = (state_q == S_EXEC) && (act_q == ACT_READ) && in_range;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(tgt_addr),
		.rd_data(rd_data)
	);

	// Command payload and the read result need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_axis_tuser;
			chr_q <= s_axis_tdata[7:0];
			row_q <= s_axis_tdata[12:8];
			col_q <= s_axis_tdata[19:13];
		end
		if (state_q == S_EXEC) begin
			res_char_q <= '0;
			res_attr_q <= '0;
		end else if (state_q == S_READ && in_range) begin
			res_char_q <= rd_data[CHAR_W-1:0];
			res_attr_q <= rd_data[CELL_W-1:CHAR_W];
		end
		if (emit) begin
			out_data_q <= {4'd0, res_attr_q, res_char_q, cur_col_q, cur_row_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			base_q       <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= ADDR_W'(CELL_COUNT - 1);
			sweep_attr_q <= RESET_ATTR;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_INIT, S_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == sweep_last_q) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (act_q)
						ACT_STREAM: begin
							if (chr_q == CHAR_CR) begin
								cur_col_q <= '0;
							end else if (wraps) begin
								cur_col_q <= '0;
								if (cur_row_q == LAST_ROW) begin
									// The top physical row becomes the new, blank bottom row.
									sweep_addr_q <= cell_addr(base_q, '0);
									sweep_last_q <= cell_addr(base_q, LAST_COL);
									sweep_attr_q <= text_attr_q;
									base_q       <= (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
									state_q      <= S_SWEEP;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end else if (printable) begin
								cur_col_q <= cur_col_q + 1'b1;
							end
						end
						ACT_CLEAR: begin
							cur_row_q    <= '0;
							cur_col_q    <= '0;
							base_q       <= '0;
							sweep_addr_q <= '0;
							sweep_last_q <= ADDR_W'(CELL_COUNT - 1);
							sweep_attr_q <= text_attr_q;
							state_q      <= S_SWEEP;
						end
						ACT_READ: begin
							state_q <= S_READ;
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end else if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_IDLE || state_q == S_DONE))
		else $error("command accepted while the sequencer is busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted command not executed in the following cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_row_q} < (ROW_W+1)'(ROWS)) && ({1'b0, cur_col_q} < (COL_W+1)'(COLUMNS))
		&& ({1'b0, base_q} < (ROW_W+1)'(ROWS)))
		else $error("cursor or row base outside the screen");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_addr} < (ADDR_W+1)'(CELL_COUNT)))
		else $error("buffer write outside the screen");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(rd_en) || !in_range)
		else $error("cell read result without a RAM read");

endmodule

// File: sim/tcw_checker.sv
`timescale 1ns / 100ps
// Result checker for the text console writer: keeps its own screen, cursor and
// attribute register, predicts a status for every accepted command, compares
// the status transfers in order and checks attribute register reads. Depends on tcw_pkg.
module tcw_checker
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // char_code[7:0], row[12:8], column[19:13], zeros
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // cursor_row[4:0], cursor_column[11:5],
	                                    // cell_char[19:12], cell_attr[27:20], zeros
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          results_owed
);
	localparam logic [2:0] ATTR_ADDR = 3'd0;

	// Laid out so that a cast from the low bits of m_axis_tdata fills it.
	typedef struct packed {
		logic [CHAR_W-1:0] attr;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} console_status_t;

	logic [CELL_W-1:0] screen [CELL_COUNT];
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic [CHAR_W-1:0] text_attr;
	console_status_t   pending_status [$];

	task automatic blank_screen(input logic [CHAR_W-1:0] attr);
		for (int i = 0; i < CELL_COUNT; i++) screen[i] = {attr, BLANK_CHAR};
	endtask

	// Start of the next line; on the bottom row the picture moves up instead.
	task automatic next_line();
		cursor_col = '0;
		if (cursor_row == ROW_W'(ROWS - 1)) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
			for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
				screen[i] = {text_attr, BLANK_CHAR};
		end else begin
			cursor_row = cursor_row + 1'b1;
		end
	endtask

	task automatic run_command(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
		input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c, output console_status_t status);
		logic in_range;
		int   idx;
		status   = '0;
		in_range = (r < ROWS) && (c < COLUMNS);
		idx      = int'(r) * COLUMNS + int'(c);
		case (act)
		ACT_STREAM: begin
			if (ch == CHAR_CR) begin
				cursor_col = '0;
			end else if (ch == CHAR_LF) begin
				next_line();
			end else if (ch != CHAR_NUL) begin
				screen[int'(cursor_row) * COLUMNS + int'(cursor_col)] = {text_attr, ch};
				if (cursor_col == COL_W'(COLUMNS - 1)) next_line();
				else cursor_col = cursor_col + 1'b1;
			end
		end
		ACT_WRITE: begin
			if (in_range) screen[idx] = {text_attr, ch};
		end
		ACT_CLEAR: begin
			blank_screen(text_attr);
			cursor_row = '0;
			cursor_col = '0;
		end
		ACT_READ: begin
			if (in_range) {status.attr, status.ch} = screen[idx];
		end
		default: begin
		end
		endcase
		status.row = cursor_row;
		status.col = cursor_col;
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_status_t seen;
		console_status_t owed;
		if (!arst_n) begin
			blank_screen(RESET_ATTR);
			cursor_row = '0;
			cursor_col = '0;
			text_attr = RESET_ATTR;
			pending_status.delete();
			mismatch_count = 0;
		end else begin
			// Retire first: a result leaving now belongs to an earlier command.
			if (m_axis_tvalid && m_axis_tready) begin
				seen = console_status_t'(m_axis_tdata[27:0]);
				if (pending_status.size() == 0) begin
					$display("%0t: unexpected status row %0d col %0d char %h attr %h",
						$time, seen.row, seen.col, seen.ch, seen.attr);
					mismatch_count++;
				end else begin
					owed = pending_status.pop_front();
					if (seen.row !== owed.row || seen.col !== owed.col ||
						seen.ch !== owed.ch || seen.attr !== owed.attr) begin
						$display("%0t: expected %0d,%0d %h %h, got %0d,%0d %h %h",
							$time, owed.row, owed.col, owed.ch, owed.attr,
							seen.row, seen.col, seen.ch, seen.attr);
						mismatch_count++;
					end
				end
			end
			if (psel && penable && pready && paddr == ATTR_ADDR) begin
				if (pwrite) begin
					text_attr = pwdata[CHAR_W-1:0];
				end else if (prdata !== 32'(text_attr)) begin
					$display("%0t: expected attribute register %h, got %h",
						$time, 32'(text_attr), prdata);
					mismatch_count++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				run_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[12:8],
					s_axis_tdata[19:13], owed);
				pending_status.push_back(owed);
			end
		end
		results_owed = pending_status.size();
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the text console writer testbench: clock, reset, command and APB
// stimulus, result back-pressure and the verdict.
// Depends on tcw_pkg, text_console_writer and tcw_checker.
module testbench
	import tcw_pkg::*;
;

	localparam int         CYCLE_LIMIT = 600000;
	localparam int         LONG_HOLD   = 300;
	localparam int         SETTLE      = 100;
	localparam logic [2:0] ATTR_ADDR   = 3'd0;
	localparam logic [2:0] SPARE_ADDR  = 3'd4;   // first address past the register list

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	int   mismatch_count;
	int   results_owed;
	int   cycle_count  = 0;
	logic calm         = 1'b0;
	logic hold_req     = 1'b0;
	logic hold_served  = 1'b0;

	text_console_writer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tcw_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatch_count(mismatch_count), .results_owed(results_owed)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_command(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
		input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, c, r, ch};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (results_owed == 0);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [2:0] addr,
		input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_attribute(input logic [CHAR_W-1:0] attr);
		drain();
		apb_access(1'b1, ATTR_ADDR, 32'(attr));
		apb_access(1'b0, ATTR_ADDR, 32'h0);
	endtask

	task automatic issue_random_command();
		int                pick;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  r;
		logic [COL_W-1:0]  c;
		pick = $urandom_range(0, 399);
		ch   = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 6) == 0) begin
			r = 5'($urandom_range(0, 31));
			c = 7'($urandom_range(0, 127));
		end else begin
			r = 5'($urandom_range(0, ROWS - 1));
			c = 7'($urandom_range(0, COLUMNS - 1));
		end
		if (pick == 0) begin
			send_command(ACT_CLEAR, ch, r, c);
		end else if (pick < 90) begin
			send_command(ACT_WRITE, ch, r, c);
		end else if (pick < 170) begin
			send_command(ACT_READ, ch, r, c);
		end else begin
			// Mostly printable text broken by newlines, so that lines wrap and the
			// screen scrolls often.
			pick = $urandom_range(0, 99);
			if (pick < 14) ch = CHAR_LF;
			else if (pick < 18) ch = CHAR_CR;
			else if (pick < 20) ch = CHAR_NUL;
			else if (pick < 85) ch = 8'($urandom_range(8'h20, 8'h7E));
			send_command(ACT_STREAM, ch, r, c);
		end
	endtask

	// Result side: short stalls at random, and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_served) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_served = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, attribute still at its reset value.
		send_command(ACT_READ, 8'h00, 5'd0, 7'd0);
		send_command(ACT_READ, 8'hFF, 5'd24, 7'd79);
		send_command(ACT_STREAM, 8'h41, 5'd0, 7'd0);
		send_command(ACT_STREAM, CHAR_NUL, 5'd31, 7'd127);
		send_command(ACT_STREAM, 8'hFF, 5'd0, 7'd0);
		send_command(ACT_STREAM, 8'h80, 5'd0, 7'd0);
		send_command(ACT_STREAM, 8'h01, 5'd0, 7'd0);
		send_command(ACT_STREAM, CHAR_CR, 5'd0, 7'd0);
		send_command(ACT_READ, 8'h00, 5'd0, 7'd1);
		send_command(ACT_STREAM, CHAR_LF, 5'd0, 7'd0);
		send_command(ACT_WRITE, 8'hFF, 5'd24, 7'd79);
		send_command(ACT_WRITE, 8'h5A, 5'd0, 7'd0);
		send_command(ACT_WRITE, 8'h11, 5'd25, 7'd0);
		send_command(ACT_WRITE, 8'h22, 5'd0, 7'd80);
		send_command(ACT_WRITE, 8'h33, 5'd31, 7'd127);
		send_command(ACT_READ, 8'h00, 5'd24, 7'd79);
		send_command(ACT_READ, 8'h00, 5'd0, 7'd0);
		send_command(ACT_READ, 8'h00, 5'd25, 7'd0);
		send_command(ACT_READ, 8'h00, 5'd0, 7'd80);
		send_command(ACT_READ, 8'hFF, 5'd31, 7'd127);
		send_command(ACT_CLEAR, 8'hFF, 5'd31, 7'd127);
		send_command(ACT_READ, 8'h00, 5'd24, 7'd79);

		set_attribute(8'h00);
		repeat (250) issue_random_command();

		// The long hold-off lands while commands keep coming, so the block backs up.
		set_attribute(8'hFF);
		hold_req = 1'b1;
		repeat (250) issue_random_command();

		set_attribute(8'($urandom_range(1, 254)));
		apb_access(1'b1, SPARE_ADDR, 32'h0000_00A5);
		apb_access(1'b0, ATTR_ADDR, 32'h0);
		repeat (150) issue_random_command();
		drain();
		repeat (100) issue_random_command();

		set_attribute(8'($urandom_range(0, 255)));
		calm = 1'b1;
		repeat (280) issue_random_command();

		drain();
		repeat (SETTLE) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
sim/tcw_checker.sv
sim/testbench.sv
